@@ hdl/top_k_row_selector_assert.svh @@
// assertion macros for the top-k row selector
`ifndef TOP_K_ROW_SELECTOR_ASSERT_SVH
`define TOP_K_ROW_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TKS_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
`define TKS_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define TKS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TKS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ hdl/tks_pkg.sv @@
package tks_pkg;
  localparam int unsigned KeyW = 64;
  localparam int unsigned CapW = 11;
  localparam int unsigned SlotW = 10;
  localparam int unsigned MaxKeptDef = 1024;
  localparam logic [KeyW-1:0] SignBit = {1'b1, {(KeyW-1){1'b0}}};

  typedef enum logic [0:0] {
    CfgCapacity   = 1'b0,
    CfgDescending = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StScanRd,
    StScanCmp,
    StDecide,
    StFinal,
    StOut
  } state_e;

  // true if key a is strictly better than key b
  function automatic logic key_better(logic [KeyW-1:0] a, logic [KeyW-1:0] b,
                                      logic desc);
    logic [KeyW-1:0] oa;
    logic [KeyW-1:0] ob;
    oa = a ^ SignBit;
    ob = b ^ SignBit;
    key_better = desc ? (oa > ob) : (oa < ob);
  endfunction
endpackage

@@ hdl/tks_key_mem.sv @@
module tks_key_mem import tks_pkg::*; #(
  parameter int unsigned MaxKept = MaxKeptDef,
  parameter int unsigned IdxW = $clog2(MaxKept)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [KeyW-1:0] wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [KeyW-1:0] rdata_o
);
  logic [KeyW-1:0] mem_q [MaxKept];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/top_k_row_selector.sv @@
// top-k row selector: keeps the capacity best signed 64-bit keys
// path: idle, decide, a scan of all kept keys once the store is full, final, result beat;
// a replaced key starts a second scan; each entry is read, then compared, on a 1r1w memory
// flow: one row at a time, ready only when idle, again in the cycle after the result beat is taken
// reset: count, capacity (16) and mode (ascending) cleared; key memory undefined
module top_k_row_selector import tks_pkg::*; #(
  parameter int unsigned MaxKept = MaxKeptDef,
  parameter int unsigned IdxW = $clog2(MaxKept),
  parameter int unsigned CntW = $clog2(MaxKept + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [CapW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [KeyW-1:0] sort_key_i,
  input  logic                   row_passes_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   stored_o,
  output logic [SlotW-1:0]       slot_o,
  output logic                   is_full_o,
  output logic signed [KeyW-1:0] worst_key_o
);
  `include "top_k_row_selector_assert.svh"

  state_e state_q, state_d;
  logic [CapW-1:0] cap_q;
  logic desc_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [KeyW-1:0] key_q, key_d;
  logic pass_q, pass_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic [KeyW-1:0] wkey_q, wkey_d;
  logic second_q, second_d;
  logic stored_q, stored_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic full_q, full_d;
  logic [KeyW-1:0] worst_q, worst_d;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;
  logic [CntW-1:0] cap_eff;
  logic [CapW-1:0] cap_c;

  // effective capacity: zero acts as one, saturate at the store depth
  always_comb begin
    cap_c = (cap_q == '0) ? CapW'(1) : cap_q;
    if ({{(32-CapW){1'b0}}, cap_c} > 32'(MaxKept)) begin
      cap_eff = CntW'(MaxKept);
    end else begin
      cap_eff = CntW'(cap_c);
    end
  end

  tks_key_mem #(.MaxKept(MaxKept), .IdxW(IdxW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q <= CapW'(16);
      desc_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgCapacity:   cap_q <= cfg_data_i;
          CfgDescending: desc_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pass_q <= pass_d;
    idx_q <= idx_d;
    widx_q <= widx_d;
    wkey_q <= wkey_d;
    second_q <= second_d;
    stored_q <= stored_d;
    slot_q <= slot_d;
    full_q <= full_d;
    worst_q <= worst_d;
  end

  // scan reads entry idx in StScanRd and compares it in StScanCmp; second scan after a replace
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    key_d = key_q;
    pass_d = pass_q;
    idx_d = idx_q;
    widx_d = widx_q;
    wkey_d = wkey_q;
    second_d = second_q;
    stored_d = stored_q;
    slot_d = slot_q;
    full_d = full_q;
    worst_d = worst_q;
    we = 1'b0;
    waddr = cnt_q[IdxW-1:0];
    wdata = key_q;
    raddr = idx_q[IdxW-1:0];
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d = sort_key_i;
          pass_d = row_passes_i;
          stored_d = 1'b0;
          slot_d = '0;
          second_d = 1'b0;
          idx_d = '0;
          widx_d = '0;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (pass_q && cnt_q < cap_eff) begin
          we = 1'b1;
          stored_d = 1'b1;
          slot_d = SlotW'(cnt_q);
          cnt_d = cnt_q + CntW'(1);
          second_d = 1'b1;
        end
        idx_d = '0;
        state_d = (cnt_d >= cap_eff && cnt_d != '0) ? StScanRd : StFinal;
      end
      StScanRd: begin
        state_d = StScanCmp;
      end
      StScanCmp: begin
        if (idx_q == '0 || key_better(wkey_q, rdata, desc_q)) begin
          wkey_d = rdata;
          widx_d = idx_q[IdxW-1:0];
        end
        idx_d = idx_q + CntW'(1);
        if (idx_d >= cnt_q) begin
          state_d = StFinal;
        end else begin
          state_d = StScanRd;
        end
      end
      StFinal: begin
        full_d = (cnt_q >= cap_eff) && (cnt_q != '0);
        worst_d = full_d ? wkey_q : '0;
        if (!second_q && pass_q && full_d && key_better(key_q, wkey_q, desc_q)) begin
          we = 1'b1;
          waddr = widx_q;
          stored_d = 1'b1;
          slot_d = SlotW'(widx_q);
          second_d = 1'b1;
          idx_d = '0;
          state_d = StScanRd;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign stored_o = stored_q;
  assign slot_o = slot_q;
  assign is_full_o = full_q;
  assign worst_key_o = worst_q;

  `TKS_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `TKS_ASSERT_IMPL(a_cnt_cap, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxKept))
  `TKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `TKS_ASSERT_IMPL(a_slot_zero, clk_i, rst_ni, out_valid_o && !stored_o, slot_o == '0)
endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import tks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxKept = 1024;
  localparam int unsigned IdleLimit = 40000;

  typedef struct packed {
    logic signed [KeyW-1:0] sort_key;
    logic                   row_passes;
  } row_t;

  typedef struct packed {
    logic                   stored;
    logic [SlotW-1:0]       slot;
    logic                   is_full;
    logic signed [KeyW-1:0] worst_key;
  } pick_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [CapW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [KeyW-1:0] sort_key_i;
  logic row_passes_i;
  logic out_valid_o;
  logic out_ready_i;
  logic stored_o;
  logic [SlotW-1:0] slot_o;
  logic is_full_o;
  logic signed [KeyW-1:0] worst_key_o;

  top_k_row_selector uut (.*);

  // predictor state
  logic [KeyW-1:0] kept_keys[MaxKept];
  int unsigned kept_n;
  logic [CapW-1:0] cap_reg;
  logic desc_reg;

  row_t  rows_pending[$];
  pick_t picks_due[$];
  int unsigned errors;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit beats(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
    logic [KeyW-1:0] oa;
    logic [KeyW-1:0] ob;
    oa = a ^ SignBit;
    ob = b ^ SignBit;
    return desc_reg ? (oa > ob) : (oa < ob);
  endfunction

  function automatic int unsigned worst_entry();
    int unsigned w;
    w = 0;
    for (int unsigned i = 1; i < kept_n; i++) begin
      if (beats(kept_keys[w], kept_keys[i])) w = i;
    end
    return w;
  endfunction

  function automatic pick_t select_row(row_t r);
    pick_t p;
    int unsigned cap;
    int unsigned w;
    p = '0;
    cap = cap_reg;
    if (cap == 0) cap = 1;
    if (cap > MaxKept) cap = MaxKept;
    if (r.row_passes) begin
      if (kept_n < cap) begin
        kept_keys[kept_n] = r.sort_key;
        p.stored = 1'b1;
        p.slot = kept_n[SlotW-1:0];
        kept_n++;
      end else begin
        w = worst_entry();
        if (beats(r.sort_key, kept_keys[w])) begin
          kept_keys[w] = r.sort_key;
          p.stored = 1'b1;
          p.slot = w[SlotW-1:0];
        end
      end
    end
    if (kept_n >= cap && kept_n > 0) begin
      p.is_full = 1'b1;
      p.worst_key = kept_keys[worst_entry()];
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic enqueue_row(row_t r);
    rows_pending = {rows_pending, r};
  endtask

  // driver: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sort_key_i <= '0;
      row_passes_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        picks_due = {picks_due, select_row({sort_key_i, row_passes_i})};
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (rows_pending.size() > 0) begin
          {sort_key_i, row_passes_i} <= rows_pending.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(20, 1);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern
  int unsigned stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
      idle_cycles <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready_i <= (stall_phase[9:8] == 2'd0) ? 1'b1 : ($urandom_range(3) != 0);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (picks_due.size() == 0) begin
          report_mismatch("unexpected beat", '0, '0);
        end else begin
          want = picks_due.pop_front();
          if (stored_o !== want.stored)
            report_mismatch("stored", KeyW'(stored_o), KeyW'(want.stored));
          if (slot_o !== want.slot)
            report_mismatch("slot", KeyW'(slot_o), KeyW'(want.slot));
          if (is_full_o !== want.is_full)
            report_mismatch("is_full", KeyW'(is_full_o), KeyW'(want.is_full));
          if (worst_key_o !== want.worst_key)
            report_mismatch("worst_key", worst_key_o, want.worst_key);
        end
      end
      if (idle_cycles > IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(5))
      0: return {1'b1, 63'd0};
      1: return {1'b0, {63{1'b1}}};
      2: return {$urandom, $urandom};
      default: return 64'($signed($urandom_range(40))) - 64'sd20;
    endcase
  endfunction

  // sampled at the falling edge so every beat of the rising edge has settled
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (rows_pending.size() != 0 || in_valid_i || picks_due.size() != 0);
    repeat (2 * MaxKept + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CapW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgCapacity) cap_reg = val;
    else desc_reg = val[0];
  endtask

  initial begin
    logic [CapW-1:0] caps[8];
    row_t r;
    caps = '{11'd0, 11'd1, 11'd3, 11'd16, 11'd7, 11'd2047, 11'd1024, 11'd5};
    errors = 0;
    kept_n = 0;
    cap_reg = 16;
    desc_reg = 0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgCapacity;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill, extremes, ties, failed rows
    enqueue_row('{64'sh8000_0000_0000_0000, 1'b1});
    enqueue_row('{64'sh7fff_ffff_ffff_ffff, 1'b1});
    enqueue_row('{64'sd0, 1'b0});
    enqueue_row('{-64'sd1, 1'b1});
    for (int i = 0; i < 14; i++) enqueue_row('{64'sd5, 1'b1});
    enqueue_row('{64'sh7fff_ffff_ffff_ffff, 1'b1});
    enqueue_row('{64'sh7fff_ffff_ffff_ffff, 1'b0});
    enqueue_row('{64'sd4, 1'b1});
    enqueue_row('{64'sd5, 1'b1});
    settle();
    // mode change mid-stream, then lower capacity below the kept count
    write_reg(CfgDescending, 11'd1);
    enqueue_row('{64'sd6, 1'b1});
    enqueue_row('{64'sh8000_0000_0000_0000, 1'b1});
    settle();
    write_reg(CfgCapacity, 11'd3);
    enqueue_row('{64'sd100, 1'b1});
    enqueue_row('{64'sd1, 1'b0});
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgCapacity, caps[ph]);
      write_reg(CfgDescending, {{(CapW-1){1'b0}}, ph[0]});
      for (int i = 0; i < ((caps[ph] >= 1000) ? 260 : 130); i++) begin
        r.sort_key = pick_key();
        r.row_passes = ($urandom_range(7) != 0);
        enqueue_row(r);
      end
      settle();
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tks_pkg.sv
hdl/tks_key_mem.sv
hdl/top_k_row_selector.sv
tb/sv/tb_top.sv
